FILE: sv/prime_table_generator_assert.svh
// Assertion macros for the prime table generator.
// Each check samples on the rising edge of clk; the first form is ignored
// while rst_n is low, the second also holds through reset.
`ifndef PRIME_TABLE_GENERATOR_ASSERT_SVH
`define PRIME_TABLE_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define PTG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTG_ASSERT(lbl, prop, msg)
`define PTG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/ptg_pkg.sv
`timescale 1ns / 1ps

package ptg_pkg;

    // Defaults for the top level parameters
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int PRIME_WIDTH_DEF = 16;

    // Entries held in the constant preload table
    localparam int PRELOAD_COUNT = 16;
    // Trial division starts at 5, skipping 2 and 3 which the wheel excludes
    localparam int FIRST_TRIAL   = 2;

    // Request codes
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] index;
    } ptg_req_t;

    typedef struct packed {
        logic [15:0] prime;
        logic [11:0] position;
        logic [15:0] largest_prime;
        logic [12:0] fill_count;
        logic        range_error;
    } ptg_rsp_t;

    // First sixteen primes
    function automatic logic [31:0] preload_prime(input logic [3:0] idx);
        logic [31:0] p;
        case (idx)
            4'd0:    p = 32'd2;
            4'd1:    p = 32'd3;
            4'd2:    p = 32'd5;
            4'd3:    p = 32'd7;
            4'd4:    p = 32'd11;
            4'd5:    p = 32'd13;
            4'd6:    p = 32'd17;
            4'd7:    p = 32'd19;
            4'd8:    p = 32'd23;
            4'd9:    p = 32'd29;
            4'd10:   p = 32'd31;
            4'd11:   p = 32'd37;
            4'd12:   p = 32'd41;
            4'd13:   p = 32'd43;
            4'd14:   p = 32'd47;
            4'd15:   p = 32'd53;
            default: p = 32'd0;
        endcase
        return p;
    endfunction

endpackage

FILE: sv/prime_table_generator.sv
`timescale 1ns / 1ps

// Prime table generator: a request item on req (req_valid/req_stall) asks for
// the prime at an index, restarts the cursor at the first prime, or advances
// the cursor. One response item per request leaves on rsp (rsp_valid/
// rsp_stall), carrying the prime, its position, the largest stored prime and
// the fill count. Out of range requests answer prime 0 with range_error set.
// Only one request is in flight; req_stall is high from acceptance until the
// response has been moved into the output register.
// Restart, unused codes and range errors go from idle straight to emit; a
// read of a stored prime passes through check and read first. Filling the
// table is done by one shared shift-subtract divider, one quotient bit per
// cycle; each trial divisor passes load, fetch and square, then the divider.
// A candidate takes one trial per stored prime from 5 up to its square root
// (fewer once a divisor turns up) and, when none does, a root check and store.
// Reset restores the sixteen preloaded primes (held in a constant table, so no
// clearing pass is needed) and the cursor to zero; the table RAM needs no reset.
// A stalled response holds in the output register; the next request is still
// accepted and is worked on, finishing once the register is free.
module prime_table_generator
    import ptg_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  ptg_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output ptg_rsp_t rsp
);

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int PW   = PRIME_WIDTH;
    localparam int BCW  = $clog2(PW + 1);
    localparam logic [PW:0] LIMIT = {1'b0, {PW{1'b1}}};

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_NEXT   = 4'd2;
    localparam logic [3:0] S_TLOAD  = 4'd3;
    localparam logic [3:0] S_TFETCH = 4'd4;
    localparam logic [3:0] S_TSQ    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_STORE  = 4'd7;
    localparam logic [3:0] S_READ   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    // Control state
    logic [3:0]      state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [PW-1:0]   last_prime_reg, last_prime_next;
    logic            wheel_four_reg, wheel_four_next;
    logic [IDXW-1:0] cursor_reg, cursor_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // Datapath
    logic [1:0]      op_reg, op_next;
    logic [IDXW-1:0] target_reg, target_next;
    logic [PW-1:0]   cand_reg, cand_next;
    logic            step_four_reg, step_four_next;
    logic [IDXW-1:0] trial_reg, trial_next;
    logic [PW-1:0]   p_reg, p_next;
    logic [2*PW-1:0] sq_reg, sq_next;
    logic [PW-1:0]   rem_reg, rem_next;
    logic [PW-1:0]   div_reg, div_next;
    logic [BCW-1:0]  bit_reg, bit_next;
    logic [15:0]     res_prime_reg, res_prime_next;
    logic [11:0]     res_pos_reg, res_pos_next;
    logic            res_err_reg, res_err_next;
    ptg_rsp_t        rsp_reg, rsp_next;

    // Table RAM
    logic [PW-1:0]   mem [TABLE_DEPTH];
    logic [PW-1:0]   mem_q;
    logic [IDXW-1:0] rd_addr;
    logic            wr_en;

    // Working signals
    logic            req_take;
    logic            out_free;
    logic [CNTW-1:0] cursor_inc;
    logic [PW:0]     cand_sum;
    logic [PW:0]     rem_shift;
    logic            rem_ge;
    logic [PW-1:0]   rem_new;
    logic [PW-1:0]   trial_prime;
    logic [PW-1:0]   target_prime;

    assign req_take   = req_valid && !req_stall;
    assign req_stall  = (state_reg != S_IDLE);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign cursor_inc = CNTW'(cursor_reg) + CNTW'(1);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Next candidate on the 6k+-1 wheel
    assign cand_sum = {1'b0, cand_reg} + (step_four_reg ? (PW+1)'(4) : (PW+1)'(2));

    // One restoring division step
    assign rem_shift = {rem_reg, div_reg[PW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, p_reg});
    assign rem_new   = rem_ge ? PW'(rem_shift - {1'b0, p_reg}) : rem_shift[PW-1:0];

    // Low entries come from the constant table
    assign trial_prime  = (CNTW'(trial_reg) < CNTW'(PRELOAD_COUNT))
                          ? PW'(preload_prime(trial_reg[3:0])) : mem_q;
    assign target_prime = (CNTW'(target_reg) < CNTW'(PRELOAD_COUNT))
                          ? PW'(preload_prime(target_reg[3:0])) : mem_q;

    // RAM port: one write, one registered read
    assign rd_addr = (state_reg == S_CHECK) ? target_reg : trial_reg;
    assign wr_en   = (state_reg == S_STORE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDXW-1:0]] <= cand_reg;
        end
        mem_q <= mem[rd_addr];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_prime_next = last_prime_reg;
        wheel_four_next = wheel_four_reg;
        cursor_next     = cursor_reg;
        rsp_valid_next  = rsp_valid_reg;
        op_next         = op_reg;
        target_next     = target_reg;
        cand_next       = cand_reg;
        step_four_next  = step_four_reg;
        trial_next      = trial_reg;
        p_next          = p_reg;
        sq_next         = sq_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        bit_next        = bit_reg;
        res_prime_next  = res_prime_reg;
        res_pos_next    = res_pos_reg;
        res_err_next    = res_err_reg;
        rsp_next        = rsp_reg;

        // Output register drains independently
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    op_next        = req.op;
                    res_prime_next = '0;
                    res_err_next   = 1'b0;
                    res_pos_next   = 12'(cursor_reg);
                    state_next     = S_EMIT;
                    case (req.op)
                        OP_READ:
                        begin
                            res_pos_next = req.index;
                            if ({1'b0, req.index} >= 13'(TABLE_DEPTH))
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                target_next = req.index[IDXW-1:0];
                                state_next  = S_CHECK;
                            end
                        end
                        OP_RESTART:
                        begin
                            cursor_next    = '0;
                            res_pos_next   = '0;
                            res_prime_next = 16'(preload_prime(4'd0));
                        end
                        OP_ADVANCE:
                        begin
                            if (cursor_inc >= CNTW'(TABLE_DEPTH))
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                target_next = cursor_inc[IDXW-1:0];
                                state_next  = S_CHECK;
                            end
                        end
                        default:
                        begin
                            // unused code: answer only
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                if (count_reg > CNTW'(target_reg))
                begin
                    state_next = S_READ;
                end
                else
                begin
                    // start one extension from the last stored prime
                    cand_next      = last_prime_reg;
                    step_four_next = wheel_four_reg;
                    state_next     = S_NEXT;
                end
            end

            S_NEXT:
            begin
                step_four_next = !step_four_reg;
                if (cand_sum > LIMIT)
                begin
                    res_prime_next = '0;
                    res_err_next   = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cand_next  = cand_sum[PW-1:0];
                    trial_next = IDXW'(FIRST_TRIAL);
                    state_next = S_TLOAD;
                end
            end

            S_TLOAD:
            begin
                if (CNTW'(trial_reg) >= count_reg)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    state_next = S_TFETCH;
                end
            end

            S_TFETCH:
            begin
                p_next     = trial_prime;
                sq_next    = trial_prime * trial_prime;
                state_next = S_TSQ;
            end

            S_TSQ:
            begin
                if (sq_reg > (2*PW)'(cand_reg))
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    rem_next   = '0;
                    div_next   = cand_reg;
                    bit_next   = BCW'(PW);
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = rem_new;
                div_next = {div_reg[PW-2:0], 1'b0};
                bit_next = bit_reg - BCW'(1);
                if (bit_reg == BCW'(1))
                begin
                    if (rem_new == '0)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        trial_next = trial_reg + IDXW'(1);
                        state_next = S_TLOAD;
                    end
                end
            end

            S_STORE:
            begin
                count_next      = count_reg + CNTW'(1);
                last_prime_next = cand_reg;
                wheel_four_next = step_four_reg;
                state_next      = S_CHECK;
            end

            S_READ:
            begin
                res_prime_next = 16'(target_prime);
                res_pos_next   = 12'(target_reg);
                if (op_reg == OP_ADVANCE)
                begin
                    cursor_next = target_reg;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_next.prime         = res_prime_reg;
                    rsp_next.position      = res_pos_reg;
                    rsp_next.largest_prime = 16'(last_prime_reg);
                    rsp_next.fill_count    = 13'(count_reg);
                    rsp_next.range_error   = res_err_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= CNTW'(PRELOAD_COUNT);
            last_prime_reg <= PW'(preload_prime(4'd15));
            wheel_four_reg <= 1'b0;
            cursor_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_prime_reg <= last_prime_next;
            wheel_four_reg <= wheel_four_next;
            cursor_reg     <= cursor_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        target_reg    <= target_next;
        cand_reg      <= cand_next;
        step_four_reg <= step_four_next;
        trial_reg     <= trial_next;
        p_reg         <= p_next;
        sq_reg        <= sq_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        bit_reg       <= bit_next;
        res_prime_reg <= res_prime_next;
        res_pos_reg   <= res_pos_next;
        res_err_reg   <= res_err_next;
        rsp_reg       <= rsp_next;
    end

`include "prime_table_generator_assert.svh"

    // Fill count stays between the preload and the capacity
    `PTG_ASSERT(a_count_range, (count_reg >= CNTW'(PRELOAD_COUNT)) && (count_reg <= CNTW'(TABLE_DEPTH)), "fill count out of range")
    // The table only grows, one prime at a time
    `PTG_ASSERT(a_count_step, (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNTW'(1)), "fill count jumped")
    // Each stored prime is larger than the last
    `PTG_ASSERT(a_prime_rises, (count_reg != $past(count_reg)) |-> (last_prime_reg > $past(last_prime_reg)), "stored prime not ascending")
    // Partial remainder stays below the divisor throughout a division
    `PTG_ASSERT(a_rem_bound, (state_reg == S_DIV) |-> (rem_reg < p_reg), "remainder not below divisor")

endmodule

FILE: verif/tb_prime_table_generator.sv
`timescale 1ns / 1ps

module tb_prime_table_generator;
    import ptg_pkg::*;

    localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
    localparam int PRIME_WIDTH    = PRIME_WIDTH_DEF;
    // A single request may extend the table up to its full depth by trial division
    localparam int WATCHDOG_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    ptg_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    ptg_rsp_t rsp;

    // Predicted table state
    logic [PRIME_WIDTH-1:0] model_primes [TABLE_DEPTH];
    int unsigned model_count;
    int unsigned model_step;
    int unsigned model_cursor;

    ptg_rsp_t rsp_expected_q [$];
    int error_count  = 0;
    int idle_cycles  = 0;
    int req_gap_max  = 15;
    int rsp_hold_max = 15;
    int rsp_hold     = 0;

    prime_table_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Trial division by stored primes from 5 upward, stopping past the root
    function automatic bit model_is_prime(longint unsigned n);
        for (int j = FIRST_TRIAL; j < model_count; j++)
        begin
            longint unsigned p = model_primes[j];
            if (p * p > n)
                break;
            if (n % p == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Append the next prime on the 6k+-1 wheel; 0 when full or too wide
    function automatic bit model_grow();
        longint unsigned cand;
        int unsigned     step;
        if (model_count >= TABLE_DEPTH || model_count == 0)
            return 1'b0;
        cand = model_primes[model_count - 1];
        step = model_step;
        forever
        begin
            cand += step;
            step = (step == 2) ? 4 : 2;
            if (cand > ((64'd1 << PRIME_WIDTH) - 1))
                return 1'b0;
            if (model_is_prime(cand))
                break;
        end
        model_primes[model_count] = cand[PRIME_WIDTH-1:0];
        model_count++;
        model_step = step;
        return 1'b1;
    endfunction

    function automatic ptg_rsp_t model_answer(int unsigned prime, int unsigned position,
                                              bit err);
        ptg_rsp_t r;
        r.prime         = prime[15:0];
        r.position      = position[11:0];
        r.largest_prime = 16'(model_primes[model_count - 1]);
        r.fill_count    = model_count[12:0];
        r.range_error   = err;
        return r;
    endfunction

    // Expected response for one accepted request; updates the predicted state
    function automatic ptg_rsp_t predict_response(ptg_req_t item);
        int unsigned next_pos;
        case (item.op)
            OP_READ:
            begin
                if (item.index >= TABLE_DEPTH)
                    return model_answer(0, item.index, 1'b1);
                while (model_count <= item.index)
                    if (!model_grow())
                        return model_answer(0, item.index, 1'b1);
                return model_answer(model_primes[item.index], item.index, 1'b0);
            end
            OP_RESTART:
            begin
                model_cursor = 0;
                return model_answer(model_primes[0], 0, 1'b0);
            end
            OP_ADVANCE:
            begin
                next_pos = model_cursor + 1;
                if (next_pos >= TABLE_DEPTH)
                    return model_answer(0, model_cursor, 1'b1);
                while (model_count <= next_pos)
                    if (!model_grow())
                        return model_answer(0, model_cursor, 1'b1);
                model_cursor = next_pos;
                return model_answer(model_primes[next_pos], next_pos, 1'b0);
            end
            default:
                return model_answer(0, model_cursor, 1'b0);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (error_count < MAX_REPORTS)
            $display("%0t ERROR %s: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    task automatic check_response(ptg_rsp_t got);
        ptg_rsp_t want;
        if (rsp_expected_q.size() == 0)
        begin
            report_mismatch("response with no request outstanding", got.prime, 0);
            return;
        end
        want = rsp_expected_q.pop_front();
        compare_field("prime", got.prime, want.prime);
        compare_field("position", got.position, want.position);
        compare_field("largest_prime", got.largest_prime, want.largest_prime);
        compare_field("fill_count", got.fill_count, want.fill_count);
        compare_field("range_error", got.range_error, want.range_error);
    endtask

    // Response side: check each item taken, then draw a stall for the next
    always @(posedge clk or negedge rst_n)
    begin : rsp_side
        int draw;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold  <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            check_response(rsp);
            draw = $urandom_range(rsp_hold_max, 0);
            rsp_hold  <= draw;
            rsp_stall <= (draw != 0);
        end
        else if (rsp_hold != 0)
        begin
            rsp_hold  <= rsp_hold - 1;
            rsp_stall <= (rsp_hold > 1);
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One request item: random gap, hold until taken, then predict
    task automatic send_request(logic [1:0] op, logic [11:0] index);
        ptg_req_t item;
        int       gap;
        item.op    = op;
        item.index = index;
        gap = $urandom_range(req_gap_max, 0);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        rsp_expected_q.insert(rsp_expected_q.size(), predict_response(req));
    endtask

    // Hold off requests until every response is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (rsp_expected_q.size() != 0)
            @(posedge clk);
    endtask

    // 0: both sides idle, 1: none, 2: sender only, 3: receiver only
    task automatic choose_idling(int mode);
        req_gap_max  = (mode == 0 || mode == 2) ? 15 : 0;
        rsp_hold_max = (mode == 0 || mode == 3) ? 15 : 0;
    endtask

    task automatic test_directed();
        choose_idling(0);
        send_request(OP_READ, 12'd0);
        send_request(OP_READ, 12'd15);
        send_request(OP_READ, 12'd16);
        send_request(OP_READ, 12'd17);
        send_request(OP_READ, 12'd20);
        send_request(OP_READ, 12'd3);
        send_request(OP_RESTART, 12'hFFF);
        send_request(OP_ADVANCE, 12'd0);
        send_request(OP_ADVANCE, 12'hABC);
        send_request(OP_UNUSED, 12'hFFF);
        send_request(OP_UNUSED, 12'd0);
        send_request(OP_READ, 12'd1024);
        send_request(OP_READ, 12'hFFF);
        send_request(OP_READ, 12'h555);
        send_request(OP_READ, 12'd40);
        choose_idling(1);
        send_request(OP_ADVANCE, 12'h543);
        send_request(OP_RESTART, 12'd0);
        send_request(OP_ADVANCE, 12'd0);
        send_request(OP_READ, 12'd45);
        send_request(OP_UNUSED, 12'h2AA);
        wait_drained();
    endtask

    // Random mix while the table is short; reads reach just past the fill
    task automatic test_small_table();
        int          pick;
        int unsigned hi;
        for (int i = 0; i < 120; i++)
        begin
            if (i % 30 == 0)
                choose_idling((i / 30) % 4);
            pick = $urandom_range(99, 0);
            hi   = model_count + 3;
            if (hi > TABLE_DEPTH - 1)
                hi = TABLE_DEPTH - 1;
            if (pick < 45)
                send_request(OP_READ, 12'($urandom_range(hi, 0)));
            else if (pick < 60)
                send_request(OP_READ, 12'($urandom_range(4095, TABLE_DEPTH)));
            else if (pick < 85)
                send_request(OP_ADVANCE, 12'($urandom_range(4095, 0)));
            else if (pick < 92)
                send_request(OP_RESTART, 12'($urandom_range(4095, 0)));
            else
                send_request(OP_UNUSED, 12'($urandom_range(4095, 0)));
        end
        wait_drained();
    endtask

    // Walk the cursor to the end of the table, filling it one prime at a time,
    // then push past capacity
    task automatic test_cursor_walk();
        int pick;
        int cap_hits;
        int n;
        cap_hits = 0;
        n = 0;
        send_request(OP_RESTART, 12'($urandom_range(4095, 0)));
        while (cap_hits < 2)
        begin
            if (n % 128 == 0)
                choose_idling((n / 128) % 4);
            n++;
            pick = $urandom_range(99, 0);
            if (pick < 90)
            begin
                if (model_cursor + 1 >= TABLE_DEPTH)
                    cap_hits++;
                send_request(OP_ADVANCE, 12'($urandom_range(4095, 0)));
            end
            else if (pick < 98)
                send_request(OP_READ, 12'($urandom_range(model_count - 1, 0)));
            else
                send_request(OP_UNUSED, 12'($urandom_range(4095, 0)));
        end
        wait_drained();
    endtask

    // Random mix against the full table
    task automatic test_full_table();
        int pick;
        for (int i = 0; i < 80; i++)
        begin
            if (i % 20 == 0)
                choose_idling((i / 20) % 4);
            pick = $urandom_range(99, 0);
            if (pick < 40)
                send_request(OP_READ, 12'($urandom_range(TABLE_DEPTH - 1, 0)));
            else if (pick < 55)
                send_request(OP_READ, 12'($urandom_range(4095, 0)));
            else if (pick < 80)
                send_request(OP_ADVANCE, 12'($urandom_range(4095, 0)));
            else if (pick < 90)
                send_request(OP_RESTART, 12'($urandom_range(4095, 0)));
            else
                send_request(OP_UNUSED, 12'($urandom_range(4095, 0)));
        end
        wait_drained();
    endtask

    initial
    begin
        // Build the preloaded primes on the wheel from 2, 3, 5
        model_primes[0] = 2;
        model_primes[1] = 3;
        model_primes[2] = 5;
        model_count     = 3;
        model_step      = 2;
        while (model_count < PRELOAD_COUNT)
            void'(model_grow());
        model_cursor = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_small_table();
        test_cursor_walk();
        test_full_table();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && rsp_expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/ptg_pkg.sv
sv/prime_table_generator.sv
verif/tb_prime_table_generator.sv
